FILE: design/bpfa_pkg.sv
`default_nettype none
package bpfa_pkg;

  // Request kinds carried in req_type.
  localparam logic [1:0] REQ_BEGIN = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;
  localparam logic [1:0] REQ_FREE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FAIL   = 2'd1;
  localparam logic [1:0] ST_IGNORE = 2'd2;

  // Memory map descriptor type for usable memory.
  localparam logic [7:0] USABLE_TYPE = 8'd7;

  // Bitmap word geometry.
  localparam int WORD_BITS  = 64;
  localparam int CHUNK_BITS = 8;

  typedef logic [31:0] count_t;

endpackage
`default_nettype wire

FILE: design/bitmap_page_frame_allocator_top.sv
`default_nettype none
// Bitmap page frame allocator with first-fit run search. One used/free bit per page
// frame is kept in a RAM of 64-bit words. Each request transaction yields exactly one
// result transaction carrying a status, the first frame of an allocated run, and the
// saturating free and total page counts. After reset, and for every begin-map request,
// a sweep writes one word per cycle to mark all frames used; no request is taken
// during the reset sweep. Add-region, allocation marking and free requests
// read-modify-write one bitmap word at a time, in a read state and then a write
// state, through the single RAM port pair. The allocation search reads one word,
// then examines eight frames per cycle, from the reserved limit up to the first
// fitting run. A free request passes through the read, write and done states
// before the block can take the next one, and a rejected request only through
// the done state. The block handles one request at a time; a finished result waits in
// the output register, and a new request may be accepted while it waits.
module bitmap_page_frame_allocator_top #(
  parameter int NUM_FRAMES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_region_type,
  input  wire logic [51:0] in_base_frame,
  input  wire logic [39:0] in_frame_count,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_alloc_frame,
  output logic [31:0]      out_free_pages,
  output logic [31:0]      out_total_pages,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_reserved_low_frames
);

  localparam int FW    = $clog2(NUM_FRAMES + 1);
  localparam int WORDS = (NUM_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int AW    = $clog2(WORDS);

  localparam logic [2:0] S_SWEEP   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_RMW_RD  = 3'd2;
  localparam logic [2:0] S_RMW_WR  = 3'd3;
  localparam logic [2:0] S_SCAN_RD = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [16:0]            resv_r;
  logic [AW-1:0]          w_r, w_nxt;
  logic                   begin_r, begin_nxt;
  logic [1:0]             kind_r, kind_nxt;
  logic [FW:0]            lo_r, lo_nxt, hi_r, hi_nxt;
  logic                   set_r, set_nxt;
  logic                   chk_r, chk_nxt;
  logic [FW:0]            pos_r, pos_nxt;
  logic [FW:0]            rs_r, rs_nxt;
  logic [FW-1:0]          rl_r, rl_nxt;
  logic [FW-1:0]          cnt_r, cnt_nxt;
  logic [FW-1:0]          lim_r, lim_nxt;
  logic [1:0]             res_st_r, res_st_nxt;
  logic [15:0]            res_fr_r, res_fr_nxt;
  bpfa_pkg::count_t       free_r, free_nxt, total_r, total_nxt;
  logic                   ov_r, ov_nxt;
  logic [1:0]             ost_r, ost_nxt;
  logic [15:0]            ofr_r, ofr_nxt;
  bpfa_pkg::count_t       ofree_r, ofree_nxt, otot_r, otot_nxt;

  // Bitmap RAM.
  logic                   we;
  logic [AW-1:0]          raddr;
  logic [63:0]            wdata, rdata;

  bpfa_ram #(.WIDTH(bpfa_pkg::WORD_BITS), .DEPTH(WORDS)) u_map (
    .clk    (clk),
    .we     (we),
    .waddr  (w_r),
    .wdata  (wdata),
    .raddr  (raddr),
    .rdata_r(rdata)
  );

  // Eight-frame search step.
  logic [7:0]    chunk;
  logic [FW:0]   sc_rs;
  logic [FW-1:0] sc_rl;
  logic          sc_found;

  assign chunk = rdata[pos_r[5:3] * bpfa_pkg::CHUNK_BITS +: bpfa_pkg::CHUNK_BITS];

  bpfa_scan #(.NUM_FRAMES(NUM_FRAMES), .FW(FW)) u_scan (
    .pos_i      (pos_r),
    .bits_i     (chunk),
    .lim_i      (lim_r),
    .cnt_i      (cnt_r),
    .run_start_i(rs_r),
    .run_len_i  (rl_r),
    .run_start_o(sc_rs),
    .run_len_o  (sc_rl),
    .found_o    (sc_found)
  );

  // Per-word mask for the range [lo, hi) being marked.
  logic [FW:0]   hi_m1;
  logic [AW-1:0] lo_word, last_word;
  logic [5:0]    lo_off;
  logic [6:0]    hi_off;
  logic [64:0]   hi_sh;
  logic [63:0]   mask;

  assign hi_m1     = hi_r - (FW+1)'(1);
  assign lo_word   = AW'(lo_r >> 6);
  assign last_word = AW'(hi_m1 >> 6);
  assign lo_off    = (w_r == lo_word) ? lo_r[5:0] : 6'd0;
  assign hi_off    = (w_r == last_word) ? ({1'b0, hi_m1[5:0]} + 7'd1) : 7'd64;
  assign hi_sh     = {65{1'b1}} << hi_off;
  assign mask      = ({64{1'b1}} << lo_off) & ~hi_sh[63:0];

  // Request decode values.
  logic [FW-1:0] lim_in, start_fw, rem, clip, lo_in, hi_in;
  logic          start_oor;
  logic [32:0]   sum_t, sum_f, sum_1;

  assign lim_in    = (32'(resv_r) > 32'(NUM_FRAMES)) ? FW'(NUM_FRAMES) : FW'(resv_r);
  assign start_oor = in_base_frame >= 52'(NUM_FRAMES);
  assign start_fw  = FW'(in_base_frame);
  assign rem       = FW'(NUM_FRAMES) - start_fw;
  assign clip      = (in_frame_count > 40'(rem)) ? rem : FW'(in_frame_count);
  assign lo_in     = (start_fw > lim_in) ? start_fw : lim_in;
  assign hi_in     = start_fw + clip;
  assign sum_t     = {1'b0, total_r} + 33'(clip);
  assign sum_f     = {1'b0, free_r} + 33'(clip);
  assign sum_1     = {1'b0, free_r} + 33'd1;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign raddr     = (state_r == S_RMW_RD || state_r == S_RMW_WR) ? w_r : AW'(pos_r >> 6);

  always_comb begin
    state_nxt  = state_r;
    w_nxt      = w_r;
    begin_nxt  = begin_r;
    kind_nxt   = kind_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    set_nxt    = set_r;
    chk_nxt    = chk_r;
    pos_nxt    = pos_r;
    rs_nxt     = rs_r;
    rl_nxt     = rl_r;
    cnt_nxt    = cnt_r;
    lim_nxt    = lim_r;
    res_st_nxt = res_st_r;
    res_fr_nxt = res_fr_r;
    free_nxt   = free_r;
    total_nxt  = total_r;
    we         = 1'b0;
    wdata      = set_r ? (rdata | mask) : (rdata & ~mask);
    ov_nxt     = ov_r & out_stall;
    ost_nxt    = ost_r;
    ofr_nxt    = ofr_r;
    ofree_nxt  = ofree_r;
    otot_nxt   = otot_r;

    unique case (state_r)
      S_SWEEP: begin
        we    = 1'b1;
        wdata = '1;
        w_nxt = w_r + AW'(1);
        if (w_r == AW'(WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = begin_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_req_type;
          lim_nxt    = lim_in;
          res_st_nxt = bpfa_pkg::ST_DONE;
          res_fr_nxt = '0;
          state_nxt  = S_DONE;
          unique case (in_req_type)
            bpfa_pkg::REQ_BEGIN: begin
              free_nxt  = '0;
              total_nxt = '0;
              begin_nxt = 1'b1;
              w_nxt     = '0;
              state_nxt = S_SWEEP;
            end
            bpfa_pkg::REQ_ADD: begin
              if (in_region_type != bpfa_pkg::USABLE_TYPE || start_oor) begin
                res_st_nxt = bpfa_pkg::ST_IGNORE;
              end else begin
                total_nxt = sum_t[32] ? '1 : sum_t[31:0];
                free_nxt  = sum_f[32] ? '1 : sum_f[31:0];
                if (lo_in < hi_in) begin
                  lo_nxt    = {1'b0, lo_in};
                  hi_nxt    = {1'b0, hi_in};
                  w_nxt     = AW'(lo_in >> 6);
                  set_nxt   = 1'b0;
                  chk_nxt   = 1'b0;
                  state_nxt = S_RMW_RD;
                end
              end
            end
            bpfa_pkg::REQ_ALLOC: begin
              if (in_frame_count == 40'd0 || in_frame_count > 40'(NUM_FRAMES)) begin
                res_st_nxt = bpfa_pkg::ST_FAIL;
              end else begin
                cnt_nxt   = FW'(in_frame_count);
                pos_nxt   = {1'b0, lim_in[FW-1:3], 3'b000};
                rs_nxt    = {1'b0, lim_in};
                rl_nxt    = '0;
                state_nxt = S_SCAN_RD;
              end
            end
            bpfa_pkg::REQ_FREE: begin
              if (start_oor || start_fw < lim_in) begin
                res_st_nxt = bpfa_pkg::ST_IGNORE;
              end else begin
                lo_nxt    = {1'b0, start_fw};
                hi_nxt    = {1'b0, start_fw} + (FW+1)'(1);
                w_nxt     = AW'(start_fw >> 6);
                set_nxt   = 1'b0;
                chk_nxt   = 1'b1;
                state_nxt = S_RMW_RD;
              end
            end
            default: begin
              res_st_nxt = bpfa_pkg::ST_IGNORE;
            end
          endcase
        end
      end
      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end
      S_RMW_WR: begin
        if (chk_r && !rdata[lo_r[5:0]]) begin
          res_st_nxt = bpfa_pkg::ST_IGNORE;
          state_nxt  = S_DONE;
        end else begin
          we = 1'b1;
          if (w_r == last_word) begin
            state_nxt = S_DONE;
            if (chk_r) begin
              free_nxt = sum_1[32] ? '1 : sum_1[31:0];
            end
            if (kind_r == bpfa_pkg::REQ_ALLOC) begin
              res_fr_nxt = 16'(lo_r);
              free_nxt   = (32'(cnt_r) >= free_r) ? '0 : free_r - 32'(cnt_r);
            end
          end else begin
            w_nxt     = w_r + AW'(1);
            state_nxt = S_RMW_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rs_nxt  = sc_rs;
        rl_nxt  = sc_rl;
        pos_nxt = pos_r + (FW+1)'(8);
        if (sc_found) begin
          lo_nxt    = sc_rs;
          hi_nxt    = sc_rs + (FW+1)'(cnt_r);
          w_nxt     = AW'(sc_rs >> 6);
          set_nxt   = 1'b1;
          chk_nxt   = 1'b0;
          state_nxt = S_RMW_RD;
        end else if (pos_nxt >= (FW+1)'(NUM_FRAMES)) begin
          res_st_nxt = bpfa_pkg::ST_FAIL;
          state_nxt  = S_DONE;
        end else if (pos_nxt[5:0] == 6'd0) begin
          state_nxt = S_SCAN_RD;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ost_nxt   = res_st_r;
          ofr_nxt   = res_fr_r;
          ofree_nxt = free_r;
          otot_nxt  = total_r;
          begin_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      w_r     <= '0;
      begin_r <= 1'b0;
      ov_r    <= 1'b0;
      free_r  <= '0;
      total_r <= '0;
      resv_r  <= 17'd4096;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      begin_r <= begin_nxt;
      ov_r    <= ov_nxt;
      free_r  <= free_nxt;
      total_r <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        resv_r <= cfg_reserved_low_frames;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    set_r    <= set_nxt;
    chk_r    <= chk_nxt;
    pos_r    <= pos_nxt;
    rs_r     <= rs_nxt;
    rl_r     <= rl_nxt;
    cnt_r    <= cnt_nxt;
    lim_r    <= lim_nxt;
    res_st_r <= res_st_nxt;
    res_fr_r <= res_fr_nxt;
    ost_r    <= ost_nxt;
    ofr_r    <= ofr_nxt;
    ofree_r  <= ofree_nxt;
    otot_r   <= otot_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_alloc_frame = ofr_r;
  assign out_free_pages  = ofree_r;
  assign out_total_pages = otot_r;

endmodule
`default_nettype wire

FILE: design/bpfa_ram.sv
`default_nettype none
module bpfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/bpfa_scan.sv
`default_nettype none
// Examines eight consecutive frames of the bitmap and extends the current free run.
module bpfa_scan #(
  parameter int NUM_FRAMES = 65536,
  parameter int FW         = 17
) (
  input  wire logic [FW:0]   pos_i,
  input  wire logic [7:0]    bits_i,
  input  wire logic [FW-1:0] lim_i,
  input  wire logic [FW-1:0] cnt_i,
  input  wire logic [FW:0]   run_start_i,
  input  wire logic [FW-1:0] run_len_i,
  output logic      [FW:0]   run_start_o,
  output logic      [FW-1:0] run_len_o,
  output logic               found_o
);

  always_comb begin
    logic [FW:0] p;
    logic        used;
    run_start_o = run_start_i;
    run_len_o   = run_len_i;
    found_o     = 1'b0;
    for (int k = 0; k < 8; k++) begin
      p    = pos_i + (FW+1)'(k);
      used = bits_i[k] | (p < {1'b0, lim_i}) | (p >= (FW+1)'(NUM_FRAMES));
      if (!found_o) begin
        if (used) begin
          run_len_o   = '0;
          run_start_o = p + (FW+1)'(1);
        end else begin
          run_len_o = run_len_o + FW'(1);
          if (run_len_o == cnt_i) begin
            found_o = 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb_bitmap_page_frame_allocator_top.sv
// Allocator request as it crosses the input channel.
typedef struct packed {
  logic [1:0]  req_type;
  logic [7:0]  region_type;
  logic [51:0] base_frame;
  logic [39:0] frame_count;
} frame_req_t;

// Result as it crosses the output channel.
typedef struct packed {
  logic [1:0]  status;
  logic [15:0] alloc_frame;
  logic [31:0] free_pages;
  logic [31:0] total_pages;
} frame_res_t;

class frame_map_scoreboard;
  localparam longint FRAMES = 65536;
  localparam longint COUNT_TOP = 64'hFFFF_FFFF;

  bit         used [FRAMES];
  longint     free_cnt;
  longint     total_cnt;
  logic [16:0] low_limit_reg;
  frame_res_t results_due [$];
  int         errors;

  function new();
    foreach (used[f]) used[f] = 1'b1;
    free_cnt = 0;
    total_cnt = 0;
    low_limit_reg = 17'd4096;
    errors = 0;
  endfunction

  function void set_low_limit(logic [16:0] v);
    low_limit_reg = v;
  endfunction

  function longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    return (s > COUNT_TOP) ? COUNT_TOP : s;
  endfunction

  // Works out the result of one accepted request, updates the frame map and
  // queues the result; the predicted result is also handed back to the caller.
  function frame_res_t note_request(frame_req_t rq);
    frame_res_t r;
    longint lim, st, cnt, i, j, f;
    bit hit, ok;
    lim = (low_limit_reg > FRAMES) ? FRAMES : longint'(low_limit_reg);
    st = longint'(rq.base_frame);
    cnt = longint'(rq.frame_count);
    r = '0;
    r.status = bpfa_pkg::ST_DONE;
    case (rq.req_type)
      bpfa_pkg::REQ_BEGIN: begin
        foreach (used[k]) used[k] = 1'b1;
        free_cnt = 0;
        total_cnt = 0;
      end
      bpfa_pkg::REQ_ADD: begin
        if (rq.region_type != bpfa_pkg::USABLE_TYPE || st >= FRAMES) begin
          r.status = bpfa_pkg::ST_IGNORE;
        end else begin
          if (cnt > FRAMES - st) cnt = FRAMES - st;
          total_cnt = sat_add(total_cnt, cnt);
          free_cnt = sat_add(free_cnt, cnt);
          for (f = (st > lim ? st : lim); f < st + cnt; f++) used[f] = 1'b0;
        end
      end
      bpfa_pkg::REQ_ALLOC: begin
        hit = 1'b0;
        i = lim;
        if (cnt != 0 && cnt <= FRAMES) begin
          while (!hit && i + cnt <= FRAMES) begin
            ok = 1'b1;
            for (j = 0; j < cnt && ok; j++) begin
              if (used[i + j]) ok = 1'b0;
            end
            if (ok) hit = 1'b1;
            else i = i + j;
          end
        end
        if (hit) begin
          for (j = 0; j < cnt; j++) used[i + j] = 1'b1;
          free_cnt = (cnt >= free_cnt) ? 0 : free_cnt - cnt;
          r.alloc_frame = i[15:0];
        end else begin
          r.status = bpfa_pkg::ST_FAIL;
        end
      end
      default: begin
        if (st < lim || st >= FRAMES || !used[st]) begin
          r.status = bpfa_pkg::ST_IGNORE;
        end else begin
          used[st] = 1'b0;
          free_cnt = sat_add(free_cnt, 1);
        end
      end
    endcase
    r.free_pages = free_cnt[31:0];
    r.total_pages = total_cnt[31:0];
    results_due.push_back(r);
    return r;
  endfunction

  function void check_result(frame_res_t got);
    frame_res_t want;
    if (results_due.size() == 0) begin
      $error("result transaction with nothing expected: status %0d", got.status);
      errors++;
      return;
    end
    want = results_due.pop_front();
    if (got.status !== want.status) begin
      $error("status: expected %0d, actual %0d", want.status, got.status);
      errors++;
    end
    if (got.alloc_frame !== want.alloc_frame) begin
      $error("alloc_frame: expected %0d, actual %0d", want.alloc_frame, got.alloc_frame);
      errors++;
    end
    if (got.free_pages !== want.free_pages) begin
      $error("free_pages: expected %0d, actual %0d", want.free_pages, got.free_pages);
      errors++;
    end
    if (got.total_pages !== want.total_pages) begin
      $error("total_pages: expected %0d, actual %0d", want.total_pages, got.total_pages);
      errors++;
    end
  endfunction
endclass

module tb_bitmap_page_frame_allocator_top;

  localparam int  FRAMES      = 65536;
  // The slowest requests are a failed search of the whole map and the marking
  // of a full-size run; this bound is several times the slowest correct run.
  localparam longint CYCLE_LIMIT = 100_000_000;
  localparam int  RANDOM_ITEMS = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_req_type;
  logic [7:0]  in_region_type;
  logic [51:0] in_base_frame;
  logic [39:0] in_frame_count;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_alloc_frame;
  logic [31:0] out_free_pages;
  logic [31:0] out_total_pages;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_reserved_low_frames;

  bitmap_page_frame_allocator_top #(.NUM_FRAMES(FRAMES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .in_region_type(in_region_type),
    .in_base_frame(in_base_frame), .in_frame_count(in_frame_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_alloc_frame(out_alloc_frame),
    .out_free_pages(out_free_pages), .out_total_pages(out_total_pages),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_reserved_low_frames(cfg_reserved_low_frames)
  );

  frame_map_scoreboard frame_sb;

  // When quiet_phase is set, neither side idles, so the block runs flat out.
  bit     quiet_phase;
  // A request for the receiver to hold off; the receiver counts the stretch
  // itself so the sender keeps offering transactions meanwhile.
  bit     hold_off_req;
  int     current_limit;
  logic [15:0] granted_frames [$];
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_bitmap_page_frame_allocator_top: done, errors");
      $finish;
    end
  end

  // Result side: check every accepted result transaction, then decide whether
  // to stall in the next cycle. Values are sampled as they stood before the edge.
  initial begin : result_side
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        frame_sb.check_result({out_status, out_alloc_frame, out_free_pages, out_total_pages});
      end
      if (hold_off_req && hold_left == 0) begin
        hold_left = 400;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_phase && ($urandom_range(99) < 35);
      end
    end
  end

  // Offers one request and holds it until the block takes it. Any idle cycles
  // before the request are spent with valid low.
  task automatic send_request(frame_req_t rq, bit may_idle);
    frame_res_t r;
    int gap;
    gap = 0;
    if (may_idle && !quiet_phase && $urandom_range(99) < 35) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= rq.req_type;
    in_region_type <= rq.region_type;
    in_base_frame  <= rq.base_frame;
    in_frame_count <= rq.frame_count;
    do @(posedge clk); while (in_stall);
    r = frame_sb.note_request(rq);
    if (rq.req_type == bpfa_pkg::REQ_ALLOC && r.status == bpfa_pkg::ST_DONE) begin
      granted_frames.push_back(16'(r.alloc_frame + 16'($urandom_range(0, 3))));
      if (granted_frames.size() > 64) void'(granted_frames.pop_front());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (frame_sb.results_due.size() != 0) @(posedge clk);
    // Allow the block to settle back to idle.
    repeat (20) @(posedge clk);
  endtask

  // Configuration writes happen only with the block idle.
  task automatic write_low_limit(logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_reserved_low_frames <= v;
    do @(posedge clk); while (!cfg_ready);
    frame_sb.set_low_limit(v);
    current_limit = int'(v);
    cfg_valid <= 1'b0;
  endtask

  function automatic frame_req_t make_req(logic [1:0] t, logic [7:0] rtype,
                                          logic [51:0] st, logic [39:0] cnt);
    frame_req_t rq;
    rq.req_type = t;
    rq.region_type = rtype;
    rq.base_frame = st;
    rq.frame_count = cnt;
    return rq;
  endfunction

  // A frame index close to the reserved limit, where most of the work happens.
  function automatic logic [51:0] near_limit();
    int base;
    base = (current_limit > FRAMES) ? FRAMES : current_limit;
    base = base + $urandom_range(0, 3000) - 200;
    if (base < 0) base = 0;
    if (base >= FRAMES) base = FRAMES - 1 - $urandom_range(0, 500);
    return 52'(base);
  endfunction

  // Builds a fresh, well-formed map: begin, then a few usable regions mixed
  // with descriptors of other types.
  task automatic build_map();
    int n;
    send_request(make_req(bpfa_pkg::REQ_BEGIN, 8'($urandom), 52'({$urandom, $urandom}),
                          40'({$urandom, $urandom})), 1);
    n = $urandom_range(2, 5);
    repeat (n) begin
      if ($urandom_range(99) < 80)
        send_request(make_req(bpfa_pkg::REQ_ADD, bpfa_pkg::USABLE_TYPE, near_limit(),
                              40'($urandom_range(1, 2048))), 1);
      else
        send_request(make_req(bpfa_pkg::REQ_ADD, 8'($urandom_range(0, 6)), near_limit(),
                              40'($urandom_range(1, 2048))), 1);
    end
  endtask

  task automatic random_request();
    frame_req_t rq;
    int pick;
    pick = $urandom_range(99);
    rq = make_req(bpfa_pkg::REQ_FREE, 8'($urandom), near_limit(),
                  40'($urandom_range(1, 64)));
    if (pick < 2) begin
      build_map();
      return;
    end else if (pick < 27) begin
      rq.req_type = bpfa_pkg::REQ_ADD;
      rq.region_type = ($urandom_range(99) < 85) ? bpfa_pkg::USABLE_TYPE : 8'($urandom);
      case ($urandom_range(9))
        0: rq.base_frame = 52'({$urandom, $urandom});
        1: rq.base_frame = 52'(16'($urandom));
        default: rq.base_frame = near_limit();
      endcase
      case ($urandom_range(9))
        0: rq.frame_count = 40'({$urandom, $urandom});
        1: rq.frame_count = 40'(16'($urandom));
        default: rq.frame_count = 40'($urandom_range(0, 512));
      endcase
    end else if (pick < 67) begin
      rq.req_type = bpfa_pkg::REQ_ALLOC;
      case ($urandom_range(19))
        0: rq.frame_count = 40'd0;
        1: rq.frame_count = 40'({$urandom, $urandom});
        2: rq.frame_count = 40'($urandom_range(65530, 65540));
        3: rq.frame_count = 40'($urandom_range(1, 4096));
        default: rq.frame_count = 40'($urandom_range(1, 64));
      endcase
    end else begin
      rq.req_type = bpfa_pkg::REQ_FREE;
      case ($urandom_range(9))
        0: rq.base_frame = 52'({$urandom, $urandom});
        1: rq.base_frame = 52'(16'($urandom));
        2, 3: rq.base_frame = near_limit();
        default: begin
          if (granted_frames.size() != 0)
            rq.base_frame = 52'(granted_frames[$urandom_range(granted_frames.size() - 1)]);
          else
            rq.base_frame = near_limit();
        end
      endcase
    end
    send_request(rq, 1);
  endtask

  initial begin : stimulus
    logic [16:0] limits [6];
    int per_phase;
    frame_sb = new();
    cycle_count = 0;
    quiet_phase = 1'b0;
    hold_off_req = 1'b0;
    current_limit = 4096;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = bpfa_pkg::REQ_BEGIN;
    in_region_type = '0;
    in_base_frame = '0;
    in_frame_count = '0;
    cfg_valid = 1'b0;
    cfg_reserved_low_frames = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reserved limit at its reset value.
    send_request(make_req(bpfa_pkg::REQ_BEGIN, 8'hFF, '1, '1), 0);
    send_request(make_req(bpfa_pkg::REQ_ADD, 8'd3, 52'd0, 40'd8192), 0);
    send_request(make_req(bpfa_pkg::REQ_ADD, 8'hFF, 52'd0, 40'd8192), 0);
    send_request(make_req(bpfa_pkg::REQ_ADD, bpfa_pkg::USABLE_TYPE, 52'd0, 40'd8192), 0);
    send_request(make_req(bpfa_pkg::REQ_ADD, bpfa_pkg::USABLE_TYPE, 52'd65536, 40'd16), 0);
    send_request(make_req(bpfa_pkg::REQ_ADD, bpfa_pkg::USABLE_TYPE, '1, 40'd16), 0);
    send_request(make_req(bpfa_pkg::REQ_ADD, bpfa_pkg::USABLE_TYPE, 52'd60000, '1), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd65537), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, '1), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd1), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd16), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd65536), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd4000), 0);
    send_request(make_req(bpfa_pkg::REQ_FREE, 8'd0, 52'd100, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_FREE, 8'd0, '1, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_FREE, 8'd0, 52'd4096, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_FREE, 8'd0, 52'd4096, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_FREE, 8'd0, 52'd65535, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_FREE, 8'd0, 52'd65536, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd1), 0);
    send_request(make_req(bpfa_pkg::REQ_BEGIN, 8'd0, 52'd0, 40'd0), 0);
    send_request(make_req(bpfa_pkg::REQ_ALLOC, 8'd0, 52'd0, 40'd1), 0);
    drain_results();

    // Random part, one phase for each reserved limit, from none reserved to
    // beyond the frame count.
    limits[0] = 17'd0;
    limits[1] = 17'd4096;
    limits[2] = 17'd65536;
    limits[3] = 17'h1FFFF;
    limits[4] = 17'($urandom_range(1, 60000));
    limits[5] = 17'd1000;
    per_phase = RANDOM_ITEMS / 6;
    for (int ph = 0; ph < 6; ph++) begin
      write_low_limit(limits[ph]);
      quiet_phase = (ph == 1);
      build_map();
      for (int k = 0; k < per_phase; k++) begin
        // Partway through one phase the receiver holds off for a long
        // stretch, so the block fills and stalls its input.
        if (ph == 4 && k == per_phase / 2) hold_off_req = 1'b1;
        // In another the sender waits for every outstanding result.
        if (ph == 5 && k == per_phase / 2) begin
          in_valid <= 1'b0;
          while (frame_sb.results_due.size() != 0) @(posedge clk);
        end
        random_request();
      end
      drain_results();
    end

    in_valid <= 1'b0;
    while (frame_sb.results_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (frame_sb.errors == 0 && frame_sb.results_due.size() == 0) begin
      $display("tb_bitmap_page_frame_allocator_top: done, clean");
    end else begin
      $display("tb_bitmap_page_frame_allocator_top: done, errors");
    end
    $finish;
  end

endmodule
